// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- hdl/smdc_pkg.sv -----
// ----------------------------------------------------------------------------
// smdc_pkg
// Field widths, request codes, register indexes and rim tables of the
// solid mask probe and disc clear block.
// ----------------------------------------------------------------------------
package smdc_pkg;

    localparam int REQ_W       = 2;
    localparam int POS_W       = 16;
    localparam int RAD_W       = 12;
    localparam int ALPHA_W     = 8;
    localparam int ACT_W_W     = 10;
    localparam int ACT_H_W     = 9;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_IDX_W   = 1;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 4;

    typedef logic [REQ_W-1:0]     t_req;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_req REQ_LOAD         = 2'd0;
    localparam t_req REQ_PROBE_POINT  = 2'd1;
    localparam t_req REQ_PROBE_CIRCLE = 2'd2;
    localparam t_req REQ_CLEAR_DISC   = 2'd3;

    localparam t_cfg_idx REG_ACTIVE_WIDTH  = 1'd0;
    localparam t_cfg_idx REG_ACTIVE_HEIGHT = 1'd1;

    localparam logic [ACT_W_W-1:0] RST_ACTIVE_WIDTH  = 10'd512;
    localparam logic [ACT_H_W-1:0] RST_ACTIVE_HEIGHT = 9'd256;

    localparam logic [ALPHA_W-1:0] SOLID_THRESHOLD = 8'd128;

    // 0.7071 rounded to 16 fraction bits.
    localparam int               DIAG_SHIFT  = 16;
    localparam logic [15:0]      DIAG_NUM    = 16'd46341;
    localparam int               DIAG_PROD_W = RAD_W + 16;

    // Pixel coordinates and bounds, signed; wide enough for any reachable value.
    localparam int COORD_W    = 18;
    // Rim sum: coordinate scaled by 2^16 plus a scaled offset.
    localparam int RIM_FULL_W = POS_W + DIAG_SHIFT + 2;
    // Distance to the disc centre inside the bounding box stays below r + 2^FRAC_BITS.
    localparam int DX_W       = RAD_W + 2;
    localparam int SQ_W       = 2 * DX_W;
    localparam int R2_W       = 2 * RAD_W;

    localparam int           PT_W      = 4;
    localparam logic [PT_W-1:0] CENTRE_PT = 4'd8;

    // Rim direction codes: 2 is a full step, 1 a diagonal step, sign gives direction.
    function automatic logic signed [2:0] rim_cos_code(input logic [PT_W-1:0] idx);
        logic signed [2:0] code;
        case (idx)
            4'd0:    code = 3'sd2;
            4'd1:    code = 3'sd1;
            4'd2:    code = 3'sd0;
            4'd3:    code = -3'sd1;
            4'd4:    code = -3'sd2;
            4'd5:    code = -3'sd1;
            4'd6:    code = 3'sd0;
            4'd7:    code = 3'sd1;
            default: code = 3'sd0;
        endcase
        return code;
    endfunction

    function automatic logic signed [2:0] rim_sin_code(input logic [PT_W-1:0] idx);
        logic signed [2:0] code;
        case (idx)
            4'd0:    code = 3'sd0;
            4'd1:    code = 3'sd1;
            4'd2:    code = 3'sd2;
            4'd3:    code = 3'sd1;
            4'd4:    code = 3'sd0;
            4'd5:    code = -3'sd1;
            4'd6:    code = -3'sd2;
            4'd7:    code = -3'sd1;
            default: code = 3'sd0;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/solid_mask_probe_and_disc_clear.sv -----
// ----------------------------------------------------------------------------
// solid_mask_probe_and_disc_clear
// One-bit terrain mask with pixel load, point and circle probes and disc clear.
// ----------------------------------------------------------------------------
// Usage:
// A request is a transaction taken at a rising edge where start is high and
// busy is low; req_type selects load, point probe, circle probe or disc clear.
// Every request returns exactly one result: o_res_valid is high for a single
// cycle with o_kind echoing the request and o_hit set when a probe found solid
// terrain. The receiver cannot stall, so the result is gone after that cycle.
// A circle probe tests up to nine points, the eight rim points and then the
// centre, and stops at the first point that hits; a disc clear walks every
// pixel in the clipped bounding box of the disc, or skips the walk when that
// box is empty.
// The mask memory has one read and one write port; probes serialize on the
// read port, and the disc walk tests one pixel per cycle through a
// three-stage distance pipeline and clears the pixels inside the disc. busy
// drops during the strobe cycle, so the next transaction may be taken while a result is being shown.
// After reset the block clears all MAX_WIDTH * MAX_HEIGHT pixels of the mask
// (131072 at the default sizes) one pixel per cycle, with busy high.
// Configuration writes are taken at any time and restore 512 x 256 on reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module solid_mask_probe_and_disc_clear #(
    parameter int MAX_WIDTH  = smdc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = smdc_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = smdc_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  smdc_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [smdc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Request channel.
    input  logic                               start,
    output logic                               busy,
    input  smdc_pkg::t_req                     i_req_type,
    input  logic signed [smdc_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [smdc_pkg::POS_W-1:0]  i_pos_y,
    input  logic [smdc_pkg::RAD_W-1:0]         i_radius,
    input  logic [smdc_pkg::ALPHA_W-1:0]       i_alpha,
    // Result channel.
    output logic                               o_res_valid,
    output smdc_pkg::t_req                     o_kind,
    output logic                               o_hit
);
    import smdc_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CDW   = COORD_W + FRAC_BITS + 1;
    localparam int RIM_SH = DIAG_SHIFT + FRAC_BITS;

    localparam logic signed [RIM_FULL_W-1:0] RIM_BIAS =
        (RIM_FULL_W'(1) <<< RIM_SH) - RIM_FULL_W'(1);
    localparam logic signed [COORD_W-1:0] MAX_W_C = COORD_W'(MAX_WIDTH);
    localparam logic signed [COORD_W-1:0] MAX_H_C = COORD_W'(MAX_HEIGHT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // Sequencer states.
    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PREP   = 4'd2;
    localparam logic [3:0] S_PT     = 4'd3;
    localparam logic [3:0] S_RD     = 4'd4;
    localparam logic [3:0] S_CHK    = 4'd5;
    localparam logic [3:0] S_WR     = 4'd6;
    localparam logic [3:0] S_CSET   = 4'd7;
    localparam logic [3:0] S_CSTART = 4'd8;
    localparam logic [3:0] S_CWALK  = 4'd9;
    localparam logic [3:0] S_CDRAIN = 4'd10;

    // Rim coordinate: c + k * r, truncated toward zero to a pixel index.
    function automatic logic signed [COORD_W-1:0] rim_px(
        input logic signed [POS_W-1:0]   c,
        input logic signed [2:0]         code,
        input logic [DIAG_PROD_W-1:0]    diag,
        input logic [RAD_W-1:0]          rad
    );
        logic signed [RIM_FULL_W-1:0] full;
        logic signed [RIM_FULL_W-1:0] off;
        logic [2:0]                   mag;
        full = RIM_FULL_W'(c) <<< DIAG_SHIFT;
        mag  = (code < 0) ? 3'(-code) : 3'(code);
        case (mag)
            3'd1:    off = $signed(RIM_FULL_W'(diag));
            3'd2:    off = $signed(RIM_FULL_W'(rad)) <<< DIAG_SHIFT;
            default: off = '0;
        endcase
        if (code < 0) begin
            full = full - off;
        end else begin
            full = full + off;
        end
        if (full < 0) begin
            full = full + RIM_BIAS;
        end
        return COORD_W'(full >>> RIM_SH);
    endfunction

    function automatic logic [AW-1:0] pix_addr(
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py
    );
        logic [AW-1:0] ya;
        ya = AW'(py[YW-1:0]);
        return AW'(ya * AW'(MAX_WIDTH) + AW'(px[XW-1:0]));
    endfunction

    // Configuration registers.
    logic [ACT_W_W-1:0] r_act_w;
    logic [ACT_H_W-1:0] r_act_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_w <= RST_ACTIVE_WIDTH;
            r_act_h <= RST_ACTIVE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ACTIVE_WIDTH:  r_act_w <= i_cfg_data[ACT_W_W-1:0];
                REG_ACTIVE_HEIGHT: r_act_h <= i_cfg_data[ACT_H_W-1:0];
                default: ;
            endcase
        end
    end

    // A register above the maximum size acts as that maximum.
    logic signed [COORD_W-1:0] act_w_c;
    logic signed [COORD_W-1:0] act_h_c;
    logic signed [COORD_W-1:0] eff_w;
    logic signed [COORD_W-1:0] eff_h;

    assign act_w_c = $signed(COORD_W'(r_act_w));
    assign act_h_c = $signed(COORD_W'(r_act_h));
    assign eff_w   = (act_w_c > MAX_W_C) ? MAX_W_C : act_w_c;
    assign eff_h   = (act_h_c > MAX_H_C) ? MAX_H_C : act_h_c;

    // Control and request registers.
    logic [3:0]                 r_state;
    logic [AW-1:0]              r_init_addr;
    logic [PT_W-1:0]            r_pt;
    t_req                       r_kind;
    logic signed [POS_W-1:0]    r_x;
    logic signed [POS_W-1:0]    r_y;
    logic [RAD_W-1:0]           r_r;
    logic [ALPHA_W-1:0]         r_alpha;
    logic [DIAG_PROD_W-1:0]     r_diag;
    logic signed [COORD_W-1:0]  r_px;
    logic signed [COORD_W-1:0]  r_py;
    logic                       r_inr;
    logic [AW-1:0]              r_addr;
    logic                       r_res_valid;
    t_req                       r_res_kind;
    logic                       r_res_hit;

    // Disc walk registers.
    logic signed [COORD_W-1:0]  r_x0;
    logic signed [COORD_W-1:0]  r_x1;
    logic signed [COORD_W-1:0]  r_y0;
    logic signed [COORD_W-1:0]  r_y1;
    logic [R2_W-1:0]            r_r2;
    logic signed [COORD_W-1:0]  r_cx;
    logic signed [COORD_W-1:0]  r_cy;
    logic                       r_a_v;
    logic signed [DX_W-1:0]     r_dx;
    logic signed [DX_W-1:0]     r_dy;
    logic [AW-1:0]              r_a_addr;
    logic                       r_b_v;
    logic [SQ_W-1:0]            r_dx2;
    logic [SQ_W-1:0]            r_dy2;
    logic [AW-1:0]              r_b_addr;

    // Mask memory ports.
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic                       mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic                       r_rdata;
    logic                       r_mem [DEPTH];

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Point being probed or loaded: address and range check.
    logic [AW-1:0] pt_addr;
    logic          pt_inr;
    assign pt_addr = pix_addr(r_px, r_py);
    assign pt_inr  = (r_px >= 0) && (r_px < eff_w) && (r_py >= 0) && (r_py < eff_h);
    assign mem_raddr = pt_addr;

    // Disc bounding box; S_CSET clips it to the active area.
    logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
    assign lo_x = ($signed(COORD_W'(r_x)) - $signed(COORD_W'(r_r))) >>> FRAC_BITS;
    assign hi_x = ($signed(COORD_W'(r_x)) + $signed(COORD_W'(r_r))) >>> FRAC_BITS;
    assign lo_y = ($signed(COORD_W'(r_y)) - $signed(COORD_W'(r_r))) >>> FRAC_BITS;
    assign hi_y = ($signed(COORD_W'(r_y)) + $signed(COORD_W'(r_r))) >>> FRAC_BITS;

    // Stage A of the walk: offsets from the centre in fixed point.
    logic signed [CDW-1:0] dx_full;
    logic signed [CDW-1:0] dy_full;
    assign dx_full = ($signed(CDW'(r_cx)) <<< FRAC_BITS) - $signed(CDW'(r_x));
    assign dy_full = ($signed(CDW'(r_cy)) <<< FRAC_BITS) - $signed(CDW'(r_y));

    // Stage B: squares; the final stage compares against the squared radius.
    logic signed [SQ_W-1:0] dx_sq;
    logic signed [SQ_W-1:0] dy_sq;
    logic [SQ_W:0]          sq_sum;
    logic                   clr_hit;
    assign dx_sq   = r_dx * r_dx;
    assign dy_sq   = r_dy * r_dy;
    assign sq_sum  = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign clr_hit = (sq_sum <= (SQ_W + 1)'(r_r2));

    logic walk_last;
    assign walk_last = (r_cx == r_x1) && (r_cy == r_y1);

    logic probe_hit;
    assign probe_hit = r_inr && r_rdata;

    // Write port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_b_addr;
        mem_wdata = 1'b0;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_init_addr;
            end
            S_WR: begin
                mem_we    = r_inr;
                mem_waddr = r_addr;
                mem_wdata = (r_alpha > SOLID_THRESHOLD);
            end
            S_CWALK, S_CDRAIN: begin
                mem_we = r_b_v && clr_hit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Distance pipeline payload.
    always_ff @(posedge i_clk) begin
        r_dx     <= dx_full[DX_W-1:0];
        r_dy     <= dy_full[DX_W-1:0];
        r_a_addr <= pix_addr(r_cx, r_cy);
        r_dx2    <= $unsigned(dx_sq);
        r_dy2    <= $unsigned(dy_sq);
        r_b_addr <= r_a_addr;
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_res_valid <= 1'b0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            r_a_v       <= (r_state == S_CWALK);
            r_b_v       <= r_a_v;
            case (r_state)
                S_INIT: begin
                    r_init_addr <= r_init_addr + AW'(1);
                    if (r_init_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_kind  <= i_req_type;
                        r_x     <= i_pos_x;
                        r_y     <= i_pos_y;
                        r_r     <= i_radius;
                        r_alpha <= i_alpha;
                        r_pt    <= (i_req_type == REQ_PROBE_CIRCLE) ? '0 : CENTRE_PT;
                        r_state <= (i_req_type == REQ_CLEAR_DISC) ? S_CSET : S_PREP;
                    end
                end
                S_PREP: begin
                    r_diag  <= DIAG_PROD_W'(r_r) * DIAG_PROD_W'(DIAG_NUM);
                    r_state <= S_PT;
                end
                S_PT: begin
                    r_px    <= rim_px(r_x, rim_cos_code(r_pt), r_diag, r_r);
                    r_py    <= rim_px(r_y, rim_sin_code(r_pt), r_diag, r_r);
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_inr   <= pt_inr;
                    r_addr  <= pt_addr;
                    r_state <= (r_kind == REQ_LOAD) ? S_WR : S_CHK;
                end
                S_CHK: begin
                    if (probe_hit || (r_pt == CENTRE_PT)) begin
                        r_res_valid <= 1'b1;
                        r_res_kind  <= r_kind;
                        r_res_hit   <= probe_hit;
                        r_state     <= S_IDLE;
                    end else begin
                        r_pt    <= r_pt + PT_W'(1);
                        r_state <= S_PT;
                    end
                end
                S_WR: begin
                    r_res_valid <= 1'b1;
                    r_res_kind  <= r_kind;
                    r_res_hit   <= 1'b0;
                    r_state     <= S_IDLE;
                end
                S_CSET: begin
                    r_x0    <= (lo_x < 0) ? '0 : lo_x;
                    r_y0    <= (lo_y < 0) ? '0 : lo_y;
                    r_x1    <= (hi_x > eff_w - COORD_W'(1)) ? eff_w - COORD_W'(1) : hi_x;
                    r_y1    <= (hi_y > eff_h - COORD_W'(1)) ? eff_h - COORD_W'(1) : hi_y;
                    r_r2    <= R2_W'(r_r) * R2_W'(r_r);
                    r_state <= S_CSTART;
                end
                S_CSTART: begin
                    r_cx <= r_x0;
                    r_cy <= r_y0;
                    // An empty box skips the walk.
                    r_state <= ((r_x0 <= r_x1) && (r_y0 <= r_y1)) ? S_CWALK : S_CDRAIN;
                end
                S_CWALK: begin
                    if (walk_last) begin
                        r_state <= S_CDRAIN;
                    end else if (r_cx == r_x1) begin
                        r_cx <= r_x0;
                        r_cy <= r_cy + COORD_W'(1);
                    end else begin
                        r_cx <= r_cx + COORD_W'(1);
                    end
                end
                S_CDRAIN: begin
                    if (!r_a_v && !r_b_v) begin
                        r_res_valid <= 1'b1;
                        r_res_kind  <= r_kind;
                        r_res_hit   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_kind      = r_res_kind;
    assign o_hit       = r_res_hit;

    // A result is shown for one cycle only.
    `ASSERT_NEXT(a_res_one_cycle, i_clk, i_rst_n, r_res_valid, !r_res_valid)
    // An accepted transaction leaves the block busy: the sequencer moves out of S_IDLE.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    // Only the clearing pass, a load and the disc walk write the mask.
    `ASSERT_SAME(a_write_owner, i_clk, i_rst_n, mem_we,
        (r_state == S_INIT) || (r_state == S_WR) || (r_state == S_CWALK) ||
        (r_state == S_CDRAIN))
    // Loads and clears never report a hit.
    `ASSERT_SAME(a_hit_probe_only, i_clk, i_rst_n, r_res_valid && r_res_hit,
        (r_res_kind == REQ_PROBE_POINT) || (r_res_kind == REQ_PROBE_CIRCLE))

endmodule
